>>> hdl/smcs_pkg.sv
package smcs_pkg;

    localparam int ROW_W      = 7;
    localparam int VAL_W      = 32;
    localparam int CELL_W     = 2 * ROW_W;
    localparam int OUT_CNT_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        ACT_PUT  = 2'd0,
        ACT_GET  = 2'd1,
        ACT_HAS  = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_BAD_DIM  = 2'd3
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT      = 2'd2;

    typedef struct packed {
        logic    latch;
        logic    scan;
        logic    shift_start;
        logic    shift;
        logic    write_hit;
        logic    append;
        logic    dec_count;
        logic    out_load;
        t_status status;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    bad_dims;
        logic    in_range;
        logic    cnt_zero;
        logic    space;
        logic    val_default;
        logic    hit;
        logic    scan_end;
        logic    shift_busy;
        logic    out_free;
    } t_sts;

endpackage

>>> hdl/smcs_ram.sv
module smcs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/smcs_datapath.sv
module smcs_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  smcs_pkg::t_cmd                         i_cmd,
    output smcs_pkg::t_sts                         o_sts,
    input  logic                                   i_cfg_we,
    input  logic [smcs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [smcs_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  smcs_pkg::t_action                      i_action,
    input  logic [smcs_pkg::ROW_W-1:0]             i_row,
    input  logic [smcs_pkg::ROW_W-1:0]             i_column,
    input  logic signed [smcs_pkg::VAL_W-1:0]      i_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [smcs_pkg::VAL_W-1:0]      o_read_value,
    output logic                                   o_found,
    output logic [1:0]                             o_status,
    output logic [smcs_pkg::OUT_CNT_W-1:0]         o_entry_count
);
    import smcs_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = 2 * ROW_W + VAL_W;
    localparam logic [31:0] CAP_L = 32'(CAPACITY);

    logic [ROW_W-1:0]        r_row_count;
    logic [ROW_W-1:0]        r_column_count;
    logic signed [VAL_W-1:0] r_default;

    t_action                 r_action;
    logic [ROW_W-1:0]        r_row;
    logic [ROW_W-1:0]        r_column;
    logic signed [VAL_W-1:0] r_value;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_idx;
    logic                    r_pend;
    logic [CNT_W-1:0]        r_pend_idx;
    logic                    r_hit;
    logic signed [VAL_W-1:0] r_hit_value;

    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_read_value;
    logic                    r_out_found;
    t_status                 r_out_status;
    logic [OUT_CNT_W-1:0]    r_out_count;

    logic [CELL_W-1:0]          cells;
    logic                       bad_dims;
    logic                       in_range;
    logic                       more;
    logic                       issue;
    logic                       is_match;
    logic                       hit;
    logic [ENT_W-1:0]           rdata;
    logic [ROW_W-1:0]           ent_row;
    logic [ROW_W-1:0]           ent_col;
    logic [VAL_W-1:0]           ent_val;
    logic                       we;
    logic [IDX_W-1:0]           waddr;
    logic [ENT_W-1:0]           wdata;
    logic [CNT_W-1:0]           pend_prev;
    logic [CNT_W+OUT_CNT_W-1:0] count_wide;
    logic signed [VAL_W-1:0]    next_read_value;

    assign cells    = CELL_W'(r_row_count) * CELL_W'(r_column_count);
    assign bad_dims = 32'(cells) > CAP_L;
    assign in_range = (r_row != '0) && (r_row <= r_row_count)
                   && (r_column != '0) && (r_column <= r_column_count);

    assign ent_row = rdata[ENT_W-1 -: ROW_W];
    assign ent_col = rdata[VAL_W +: ROW_W];
    assign ent_val = rdata[VAL_W-1:0];

    assign is_match = (r_action == ACT_HAS) ? (ent_val == r_value)
                    : ((ent_row == r_row) && (ent_col == r_column));
    assign hit   = r_pend && is_match;
    assign more  = r_idx < r_count;
    assign issue = (i_cmd.scan || i_cmd.shift) && more;

    assign pend_prev = r_pend_idx - CNT_W'(1);

    always_comb begin
        we    = 1'b0;
        waddr = r_count[IDX_W-1:0];
        wdata = {r_row, r_column, r_value};
        if (i_cmd.write_hit) begin
            we    = 1'b1;
            waddr = r_pend_idx[IDX_W-1:0];
        end else if (i_cmd.append) begin
            we    = 1'b1;
        end else if (i_cmd.shift && r_pend) begin
            we    = 1'b1;
            waddr = pend_prev[IDX_W-1:0];
            wdata = rdata;
        end
    end

    smcs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    assign o_sts.action      = r_action;
    assign o_sts.bad_dims    = bad_dims;
    assign o_sts.in_range    = in_range;
    assign o_sts.cnt_zero    = (r_count == '0);
    assign o_sts.space       = 32'(r_count) < 32'(cells);
    assign o_sts.val_default = (r_value == r_default);
    assign o_sts.hit         = hit;
    assign o_sts.scan_end    = r_pend && ((r_pend_idx + CNT_W'(1)) == r_count);
    assign o_sts.shift_busy  = more || r_pend;
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        next_read_value = '0;
        if ((r_action == ACT_GET) && (i_cmd.status == ST_OK)) begin
            next_read_value = r_hit ? r_hit_value : r_default;
        end
    end

    assign count_wide = {{OUT_CNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= '0;
            r_column_count <= '0;
            r_default      <= '0;
            r_count        <= '0;
            r_idx          <= '0;
            r_pend         <= 1'b0;
            r_hit          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROW_COUNT:    r_row_count    <= i_cfg_data[ROW_W-1:0];
                    CFG_COLUMN_COUNT: r_column_count <= i_cfg_data[ROW_W-1:0];
                    CFG_DEFAULT:      r_default      <= $signed(i_cfg_data[VAL_W-1:0]);
                    default: ;
                endcase
            end
            if (i_cmd.latch) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
                r_hit  <= 1'b0;
            end else if (i_cmd.shift_start) begin
                r_idx  <= r_pend_idx + CNT_W'(1);
                r_pend <= 1'b0;
            end else if (i_cmd.scan || i_cmd.shift) begin
                if (issue) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                r_pend <= issue;
            end
            if (i_cmd.scan && hit) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= i_action;
            r_row    <= i_row;
            r_column <= i_column;
            r_value  <= i_value;
        end
        if ((i_cmd.scan || i_cmd.shift) && !i_cmd.shift_start && !i_cmd.latch) begin
            r_pend_idx <= r_idx;
        end
        if (i_cmd.scan && hit) begin
            r_hit_value <= $signed(ent_val);
        end
        if (i_cmd.out_load) begin
            r_out_read_value <= next_read_value;
            r_out_found      <= (r_action == ACT_HAS) && (i_cmd.status == ST_OK) && r_hit;
            r_out_status     <= i_cmd.status;
            r_out_count      <= count_wide[OUT_CNT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_read_value;
    assign o_found       = r_out_found;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAP_L)
        else $error("entry count exceeds capacity");

    a_write_hit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_hit |-> r_pend)
        else $error("overwrite issued without a compared entry");

    a_shift_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift && r_pend) |-> (r_pend_idx != '0))
        else $error("compaction would write below slot zero");

endmodule

>>> hdl/smcs_ctrl.sv
module smcs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  smcs_pkg::t_sts i_sts,
    output smcs_pkg::t_cmd o_cmd
);
    import smcs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_SEARCH = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_RESP   = 5'b10000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_status;
    t_status n_status;
    t_cmd    cmd;
    logic    miss_append;
    t_status miss_status;

    assign miss_append = (i_sts.action == ACT_PUT) && i_sts.space && !i_sts.val_default;
    assign miss_status = ((i_sts.action == ACT_PUT) && !i_sts.space) ? ST_NO_SPACE : ST_OK;

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        cmd        = '0;
        cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state  = S_RESP;
                n_status = ST_OK;
                if (i_sts.bad_dims) begin
                    n_status = ST_BAD_DIM;
                end else if (i_sts.action == ACT_NONE) begin
                    n_status = ST_OK;
                end else if ((i_sts.action != ACT_HAS) && !i_sts.in_range) begin
                    n_status = ST_RANGE;
                end else if (i_sts.cnt_zero) begin
                    cmd.append = miss_append;
                    n_status   = miss_status;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    n_status = ST_OK;
                    n_state  = S_RESP;
                    if (i_sts.action == ACT_PUT) begin
                        if (i_sts.val_default) begin
                            cmd.shift_start = 1'b1;
                            n_state         = S_SHIFT;
                        end else begin
                            cmd.write_hit = 1'b1;
                        end
                    end
                end else if (i_sts.scan_end) begin
                    cmd.append = miss_append;
                    n_status   = miss_status;
                    n_state    = S_RESP;
                end
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                if (!i_sts.shift_busy) begin
                    cmd.dec_count = 1'b1;
                    n_state       = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;

    a_shift_only_on_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (i_sts.action == ACT_PUT))
        else $error("compaction running for an item that is not a put");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a transaction still waiting");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("controller left idle without an accepted transaction");

endmodule

>>> hdl/sparse_matrix_coordinate_store_core.sv
// Sparse matrix store holding up to CAPACITY (row, column, value) entries in a packed list,
// with every unlisted cell reading as the configured default value. Items are taken one at a
// time: a rejected item, or one that meets an empty list, goes from the decide state straight
// to its result; a put, get or contains item otherwise searches the list entry by entry up to
// and including a match (the whole stored count on a miss). A put that deletes an entry then
// moves every later entry down one slot before its result is offered. The pace is set by the
// entry memory, which gives one registered read per cycle. A finished result waits in an
// output register, so the next transaction is accepted while it is held.
module sparse_matrix_coordinate_store_core #(
    parameter int CAPACITY = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [smcs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [smcs_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_action,
    input  logic [smcs_pkg::ROW_W-1:0]             i_row,
    input  logic [smcs_pkg::ROW_W-1:0]             i_column,
    input  logic signed [smcs_pkg::VAL_W-1:0]      i_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [smcs_pkg::VAL_W-1:0]      o_read_value,
    output logic                                   o_found,
    output logic [1:0]                             o_status,
    output logic [smcs_pkg::OUT_CNT_W-1:0]         o_entry_count
);
    import smcs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    smcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    smcs_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_action      (t_action'(i_action)),
        .i_row         (i_row),
        .i_column      (i_column),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_value  (o_read_value),
        .o_found       (o_found),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule
